@@ hw/rtl/butterworth_lowpass_biquad_macros.svh @@
// Assertion macros used by the checker of this block.
`ifndef BUTTERWORTH_LOWPASS_BIQUAD_MACROS_SVH
`define BUTTERWORTH_LOWPASS_BIQUAD_MACROS_SVH

// Checked on every clock edge outside reset.
`define BWLP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define BWLP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/bwlp_pkg.sv @@
package bwlp_pkg;

    localparam int COEF_WIDTH          = 20;
    localparam int SAMPLE_WIDTH_DEF    = 16;
    localparam int COEF_FRAC_BITS_DEF  = 16;
    localparam int STATE_WIDTH_DEF     = 32;
    localparam int CFG_INDEX_WIDTH     = 2;
    localparam int PC_WIDTH            = 3;

    // register map
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_ENABLE = 2'd0,
        REG_B0     = 2'd1,
        REG_A1     = 2'd2,
        REG_A2     = 2'd3
    } t_reg_idx;

    // multiplier operand pair
    typedef enum logic [1:0] {
        MUL_NONE = 2'd0,
        MUL_D1A1 = 2'd1,
        MUL_D2A2 = 2'd2,
        MUL_SB0  = 2'd3
    } t_mul_op;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_SUB  = 2'd2
    } t_acc_op;

    typedef enum logic [1:0] {
        OUT_NONE = 2'd0,
        OUT_FILT = 2'd1,
        OUT_BYP  = 2'd2
    } t_out_sel;

    typedef enum logic [1:0] {
        JMP_NEXT   = 2'd0,
        JMP_BYPASS = 2'd1,
        JMP_END    = 2'd2
    } t_jump;

    // program addresses
    localparam logic [PC_WIDTH-1:0] STEP_DISPATCH = 3'd0;
    localparam logic [PC_WIDTH-1:0] STEP_MAC_A2   = 3'd1;
    localparam logic [PC_WIDTH-1:0] STEP_MAC_END  = 3'd2;
    localparam logic [PC_WIDTH-1:0] STEP_DELAY    = 3'd3;
    localparam logic [PC_WIDTH-1:0] STEP_GAIN     = 3'd4;
    localparam logic [PC_WIDTH-1:0] STEP_OUT      = 3'd5;
    localparam logic [PC_WIDTH-1:0] STEP_BYPASS   = 3'd6;

    typedef struct packed {
        t_mul_op               mul_op;
        t_acc_op               acc_op;
        logic                  ld_w;
        t_out_sel              out_sel;
        t_jump                 jump;
        logic [PC_WIDTH-1:0]   target;
    } t_uword;

    // sequencer -> datapath
    typedef struct packed {
        t_mul_op  mul_op;
        t_acc_op  acc_op;
        logic     ld_w;
        logic     fin_filt;
        logic     fin_byp;
    } t_ctrl;

    function automatic t_uword ucode(input logic [PC_WIDTH-1:0] pc);
        t_uword w;
        w = '{MUL_NONE, ACC_HOLD, 1'b0, OUT_NONE, JMP_NEXT, STEP_DISPATCH};
        unique case (pc)
            STEP_DISPATCH: w = '{MUL_D1A1, ACC_LOAD, 1'b0, OUT_NONE, JMP_BYPASS, STEP_BYPASS};
            STEP_MAC_A2:   w = '{MUL_D2A2, ACC_SUB,  1'b0, OUT_NONE, JMP_NEXT, STEP_DISPATCH};
            STEP_MAC_END:  w = '{MUL_NONE, ACC_SUB,  1'b0, OUT_NONE, JMP_NEXT, STEP_DISPATCH};
            STEP_DELAY:    w = '{MUL_NONE, ACC_HOLD, 1'b1, OUT_NONE, JMP_NEXT, STEP_DISPATCH};
            STEP_GAIN:     w = '{MUL_SB0,  ACC_HOLD, 1'b0, OUT_NONE, JMP_NEXT, STEP_DISPATCH};
            STEP_OUT:      w = '{MUL_NONE, ACC_HOLD, 1'b0, OUT_FILT, JMP_END, STEP_DISPATCH};
            STEP_BYPASS:   w = '{MUL_NONE, ACC_HOLD, 1'b0, OUT_BYP,  JMP_END, STEP_DISPATCH};
            default:       w = '{MUL_NONE, ACC_HOLD, 1'b0, OUT_NONE, JMP_END, STEP_DISPATCH};
        endcase
        return w;
    endfunction

endpackage

@@ hw/rtl/bwlp_seq.sv @@
module bwlp_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_enable,
    input  logic               i_out_free,
    output logic               o_busy,
    output bwlp_pkg::t_ctrl    o_ctrl
);

    logic [bwlp_pkg::PC_WIDTH-1:0] r_pc, n_pc;
    logic                          r_busy, n_busy;
    bwlp_pkg::t_uword              uw;

    assign uw = bwlp_pkg::ucode(r_pc);

    always_comb begin
        n_pc   = r_pc;
        n_busy = r_busy;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_pc   = bwlp_pkg::STEP_DISPATCH;
            end
        end else begin
            unique case (uw.jump)
                bwlp_pkg::JMP_NEXT: begin
                    n_pc = r_pc + bwlp_pkg::PC_WIDTH'(1);
                end
                bwlp_pkg::JMP_BYPASS: begin
                    n_pc = i_enable ? r_pc + bwlp_pkg::PC_WIDTH'(1) : uw.target;
                end
                bwlp_pkg::JMP_END: begin
                    // hold on the last step until the result register is free
                    if (i_out_free) begin
                        n_busy = 1'b0;
                    end
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= bwlp_pkg::STEP_DISPATCH;
            r_busy <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_busy <= n_busy;
        end
    end

    always_comb begin
        o_ctrl.mul_op   = r_busy ? uw.mul_op : bwlp_pkg::MUL_NONE;
        o_ctrl.acc_op   = r_busy ? uw.acc_op : bwlp_pkg::ACC_HOLD;
        o_ctrl.ld_w     = r_busy & uw.ld_w;
        o_ctrl.fin_filt = r_busy & (uw.out_sel == bwlp_pkg::OUT_FILT) & i_out_free;
        o_ctrl.fin_byp  = r_busy & (uw.out_sel == bwlp_pkg::OUT_BYP) & i_out_free;
    end

    assign o_busy = r_busy;

endmodule

@@ hw/rtl/bwlp_dp.sv @@
module bwlp_dp #(
    parameter int SAMPLE_WIDTH   = bwlp_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = bwlp_pkg::COEF_FRAC_BITS_DEF,
    parameter int STATE_WIDTH    = bwlp_pkg::STATE_WIDTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_load,
    input  logic signed [SAMPLE_WIDTH-1:0]          i_x,
    input  bwlp_pkg::t_ctrl                         i_ctrl,
    input  logic signed [bwlp_pkg::COEF_WIDTH-1:0]  i_b0,
    input  logic signed [bwlp_pkg::COEF_WIDTH-1:0]  i_a1,
    input  logic signed [bwlp_pkg::COEF_WIDTH-1:0]  i_a2,
    output logic signed [SAMPLE_WIDTH-1:0]          o_y,
    output logic                                    o_sat,
    output logic                                    o_sub
);

    localparam int CW    = bwlp_pkg::COEF_WIDTH;
    localparam int SW    = SAMPLE_WIDTH;
    localparam int CF    = COEF_FRAC_BITS;
    localparam int STW   = STATE_WIDTH;
    localparam int SUM_W = STW + 2;
    localparam int P_W   = SUM_W + CW;
    localparam int AW0   = (STW + CW > SW + CF) ? STW + CW : SW + CF;
    localparam int ACC_W = ((AW0 > STW + CF) ? AW0 : STW + CF) + 2;
    localparam int Y_W   = (P_W + 1 > CF + SW + 1) ? P_W + 1 : CF + SW + 1;

    localparam logic [ACC_W-1:0] ACC_HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (CF - 1);
    localparam logic [Y_W-1:0]   Y_HALF   = {{(Y_W-1){1'b0}}, 1'b1} << (CF - 1);
    localparam logic [SW-1:0]    Y_MAX    = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0]    Y_MIN    = {1'b1, {(SW-1){1'b0}}};

    logic signed [SW-1:0]    r_x;
    logic signed [STW-1:0]   r_d1, r_d2, r_w;
    logic                    r_sub;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [P_W-1:0]   r_prod;
    logic signed [ACC_W-1:0] r_acc, n_acc;

    logic signed [SUM_W-1:0] mul_a;
    logic signed [CW-1:0]    mul_b;
    logic signed [P_W-1:0]   prod_c;
    logic signed [ACC_W-1:0] acc_x;

    logic [ACC_W-1:CF+STW-1] w_hi;
    logic                    w_fit;
    logic signed [STW-1:0]   w_sel;
    logic signed [SUM_W-1:0] n_sum;

    logic signed [Y_W-1:0]   y_acc;
    logic [Y_W-1:CF+SW-1]    y_hi;
    logic                    y_fit;
    logic signed [SW-1:0]    y_clip;

    // shared multiplier
    always_comb begin
        unique case (i_ctrl.mul_op)
            bwlp_pkg::MUL_D1A1: begin
                mul_a = SUM_W'(r_d1);
                mul_b = i_a1;
            end
            bwlp_pkg::MUL_D2A2: begin
                mul_a = SUM_W'(r_d2);
                mul_b = i_a2;
            end
            default: begin
                mul_a = r_sum;
                mul_b = i_b0;
            end
        endcase
    end

    assign prod_c = mul_a * mul_b;

    // x in Q.CF with the rounding half folded in
    assign acc_x = (ACC_W'(r_x) <<< CF) + $signed(ACC_HALF);

    always_comb begin
        unique case (i_ctrl.acc_op)
            bwlp_pkg::ACC_LOAD: n_acc = acc_x;
            bwlp_pkg::ACC_SUB:  n_acc = r_acc - ACC_W'(r_prod);
            default:            n_acc = r_acc;
        endcase
    end

    // new delay value, replaced by the sample when out of range
    assign w_hi  = r_acc[ACC_W-1:CF+STW-1];
    assign w_fit = (&w_hi) | ~(|w_hi);
    assign w_sel = w_fit ? r_acc[CF+STW-1:CF] : STW'(r_x);
    assign n_sum = SUM_W'(w_sel) + (SUM_W'(r_d1) <<< 1) + SUM_W'(r_d2);

    // output rounding and clipping
    assign y_acc  = Y_W'(r_prod) + $signed(Y_HALF);
    assign y_hi   = y_acc[Y_W-1:CF+SW-1];
    assign y_fit  = (&y_hi) | ~(|y_hi);
    assign y_clip = y_fit ? y_acc[CF+SW-1:CF] : (y_acc[Y_W-1] ? $signed(Y_MIN) : $signed(Y_MAX));

    assign o_y   = i_ctrl.fin_byp ? r_x : y_clip;
    assign o_sat = ~i_ctrl.fin_byp & ~y_fit;
    assign o_sub = ~i_ctrl.fin_byp & r_sub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else if (i_ctrl.fin_filt) begin
            r_d2 <= r_d1;
            r_d1 <= r_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x <= i_x;
        end
        if (i_ctrl.mul_op != bwlp_pkg::MUL_NONE) begin
            r_prod <= prod_c;
        end
        r_acc <= n_acc;
        if (i_ctrl.ld_w) begin
            r_w   <= w_sel;
            r_sub <= ~w_fit;
            r_sum <= n_sum;
        end
    end

endmodule

@@ hw/rtl/butterworth_lowpass_biquad.sv @@
// Filtered item: accepted, then six program steps; the last step writes the result register.
// Bypassed item (enable clear): two steps, the last writes the sample unchanged into it.
// One item at a time: a new item is accepted only once the last has finished. The shared multiplier
// (three products per item) takes one step per cycle; the last step waits for the result register.
// Reset (i_rst_n low, synchronous): the configuration registers and both delay elements go to zero,
// the sequencer goes idle and no result is pending.
module butterworth_lowpass_biquad #(
    parameter int SAMPLE_WIDTH   = bwlp_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = bwlp_pkg::COEF_FRAC_BITS_DEF,
    parameter int STATE_WIDTH    = bwlp_pkg::STATE_WIDTH_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    // input samples
    input  logic                                        i_s_axis_tvalid,
    output logic                                        o_s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]           i_s_axis_tdata,  // sample_in
    // filtered samples
    output logic                                        o_m_axis_tvalid,
    input  logic                                        i_m_axis_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]           o_m_axis_tdata,  // sample_out
    output logic [1:0]                                  o_m_axis_tuser,  // state_substituted, out_saturated
    // register writes
    input  logic                                        i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  logic [bwlp_pkg::CFG_INDEX_WIDTH-1:0]        i_cfg_index,
    input  logic [bwlp_pkg::COEF_WIDTH-1:0]             i_cfg_data
);

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int CW      = bwlp_pkg::COEF_WIDTH;

    // configuration registers
    logic                  r_enable;
    logic signed [CW-1:0]  r_b0, r_a1, r_a2;

    // result register: lets the sequencer work on an item while the
    // previous result is still waiting downstream
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_y;
    logic                           r_out_sat, r_out_sub;

    logic                           busy;
    logic                           in_acc;
    logic                           out_free;
    bwlp_pkg::t_ctrl                ctrl;
    logic signed [SAMPLE_WIDTH-1:0] dp_y;
    logic                           dp_sat, dp_sub;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = ~busy;
    assign in_acc          = i_s_axis_tvalid & ~busy;
    assign out_free        = ~r_out_valid | i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_b0     <= '0;
            r_a1     <= '0;
            r_a2     <= '0;
        end else if (i_cfg_valid) begin
            unique case (bwlp_pkg::t_reg_idx'(i_cfg_index))
                bwlp_pkg::REG_ENABLE: r_enable <= i_cfg_data[0];
                bwlp_pkg::REG_B0:     r_b0     <= i_cfg_data;
                bwlp_pkg::REG_A1:     r_a1     <= i_cfg_data;
                bwlp_pkg::REG_A2:     r_a2     <= i_cfg_data;
                default:              r_enable <= r_enable;
            endcase
        end
    end

    // step program: dispatch on enable, two MAC steps for the feedback,
    // delay update and sum, gain multiply, then round/clip into the result register
    bwlp_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_acc),
        .i_enable   (r_enable),
        .i_out_free (out_free),
        .o_busy     (busy),
        .o_ctrl     (ctrl)
    );

    bwlp_dp #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .STATE_WIDTH    (STATE_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_acc),
        .i_x     ($signed(i_s_axis_tdata[SAMPLE_WIDTH-1:0])),
        .i_ctrl  (ctrl),
        .i_b0    (r_b0),
        .i_a1    (r_a1),
        .i_a2    (r_a2),
        .o_y     (dp_y),
        .o_sat   (dp_sat),
        .o_sub   (dp_sub)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.fin_filt | ctrl.fin_byp) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.fin_filt | ctrl.fin_byp) begin
            r_out_y   <= dp_y;
            r_out_sat <= dp_sat;
            r_out_sub <= dp_sub;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TDATA_W'($unsigned(r_out_y));
    assign o_m_axis_tuser  = {r_out_sub, r_out_sat};

endmodule

@@ hw/rtl/bwlp_chk.sv @@
`include "butterworth_lowpass_biquad_macros.svh"

module bwlp_chk #(
    parameter int SAMPLE_WIDTH = bwlp_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_axis_tvalid,
    input  logic                                   o_s_axis_tready,
    input  logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      o_m_axis_tdata,
    input  logic [1:0]                             o_m_axis_tuser
);

    // a stalled result keeps its value
    `BWLP_ASSERT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "result changed while stalled")

    // reset leaves nothing pending and the input open
    `BWLP_ASSERT_ALWAYS(a_reset, !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready, "bad state after reset")

    // one item at a time
    `BWLP_ASSERT(a_one_item, i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready, "input open while an item is in work")

    // a new result appears only as its item finishes
    `BWLP_ASSERT(a_result_ends_item, $rose(o_m_axis_tvalid) |-> o_s_axis_tready, "result shown while an item is still in work")

endmodule

bind butterworth_lowpass_biquad bwlp_chk #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_bwlp_chk (.*);
